[src/atomic_byte_ring_buffer_defines.svh]
// Assertion macros for the atomic byte ring buffer.
// Included by the RTL files that carry concurrent checks; depends on nothing.
`ifndef ATOMIC_BYTE_RING_BUFFER_DEFINES_SVH
`define ATOMIC_BYTE_RING_BUFFER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is low.
`define ABRB_ASSERT_IMPL(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("abrb assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ABRB_ASSERT_NEXT(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("abrb assertion failed");

`else

`define ABRB_ASSERT_IMPL(name, ck, rn, ante, cons)
`define ABRB_ASSERT_NEXT(name, ck, rn, ante, cons)

`endif

`endif

[src/abrb_pkg.sv]
// Shared widths, codes and types of the atomic byte ring buffer.
// Used by the channel interfaces, the result pipe and the top level.
package abrb_pkg;

  // Fixed payload widths.
  localparam int LEN_W  = 7;
  localparam int DATA_W = 8;

  // Default storage depth in bytes.
  localparam int DEPTH_DEF = 64;

  // Operation codes on the input channel.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Result kinds on the output channel.
  localparam logic KIND_WSTAT = 1'b0;
  localparam logic KIND_RDATA = 1'b1;

  // Descriptor of one result on its way to the output register.
  typedef struct packed {
    logic             kind;
    logic [LEN_W-1:0] count;
    logic             last;
    logic             from_mem;
  } result_meta_t;

endpackage

[src/abrb_in_if.sv]
// Input channel of the atomic byte ring buffer: valid/ready plus one item.
// Depends on abrb_pkg for the payload widths.
interface abrb_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [abrb_pkg::LEN_W-1:0]  length;
  logic [abrb_pkg::DATA_W-1:0] data_in;

  modport source (output valid, op, length, data_in, input ready);
  modport sink   (input valid, op, length, data_in, output ready);
endinterface

[src/abrb_out_if.sv]
// Result channel of the atomic byte ring buffer: valid/ready plus one result.
// Depends on abrb_pkg for the payload widths.
interface abrb_out_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [abrb_pkg::LEN_W-1:0]  moved_count;
  logic [abrb_pkg::DATA_W-1:0] read_data;
  logic                        last_of_run;

  modport source (output valid, kind, moved_count, read_data, last_of_run, input ready);
  modport sink   (input valid, kind, moved_count, read_data, last_of_run, output ready);
endinterface

[src/abrb_result_pipe.sv]
// Two-stage result path: memory-data stage followed by the output register.
// Depends on abrb_pkg and abrb_out_if.
module abrb_result_pipe (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  abrb_pkg::result_meta_t      meta,
  input  logic [abrb_pkg::DATA_W-1:0] mem_q,
  output logic                        take,
  abrb_out_if.source                  out_bus
);

  logic                        pend_r;
  abrb_pkg::result_meta_t      meta_r;
  logic                        out_valid_r;
  logic                        kind_r;
  logic [abrb_pkg::LEN_W-1:0]  count_r;
  logic [abrb_pkg::DATA_W-1:0] data_r;
  logic                        last_r;
  logic                        advance;

  // The output register frees up when it is empty or its beat is taken.
  assign advance = !out_valid_r || out_bus.ready;
  assign take    = !pend_r || advance;

  // Control: stage occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= pend_r;
      end
      if (take) begin
        pend_r <= load;
      end
    end
  end

  // Payload: the memory read data is held by the caller while this stage waits.
  always_ff @(posedge clk) begin
    if (take && load) begin
      meta_r <= meta;
    end
    if (advance && pend_r) begin
      kind_r  <= meta_r.kind;
      count_r <= meta_r.count;
      last_r  <= meta_r.last;
      data_r  <= meta_r.from_mem ? mem_q : '0;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.kind        = kind_r;
  assign out_bus.moved_count = count_r;
  assign out_bus.read_data   = data_r;
  assign out_bus.last_of_run = last_r;

endmodule

[src/atomic_byte_ring_buffer.sv]
// Top level of the atomic byte ring buffer: byte store, pointers, run tracking.
// Depends on abrb_pkg, abrb_in_if, abrb_out_if, abrb_result_pipe and the defines header.
//
//   channel   | dir | beat contents
//   ----------+-----+------------------------------------------------
//   in_bus    | in  | op, length, data_in
//   out_bus   | out | kind, moved_count, read_data, last_of_run
//   cfg_*     | in  | cfg_wr_data (buffer size), written when cfg_wr_en
//
// A write item or a refused read needs no sequencer; write items may follow back to back.
// An accepted read of N bytes starts the read sequencer, which then delivers one byte per
// cycle, unless the output stalls, through the single read port of the byte store.
// Reset is synchronous; the byte store is not cleared, so there is no clearing pass.
// A stalled output, with the data stage full, holds the read sequencer and the input.
`include "atomic_byte_ring_buffer_defines.svh"

module atomic_byte_ring_buffer #(
  parameter int DEPTH = abrb_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  abrb_in_if.sink                    in_bus,
  abrb_out_if.source                 out_bus,
  input  logic                       cfg_wr_en,
  input  logic [abrb_pkg::LEN_W-1:0] cfg_wr_data
);

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int SIZE_W = $clog2(DEPTH + 1);
  localparam int LEN_W  = abrb_pkg::LEN_W;
  localparam int DATA_W = abrb_pkg::DATA_W;

  // Step a pointer by one, wrapping at the configured size.
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p,
                                               input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] nxt;
    nxt = SIZE_W'(p) + SIZE_W'(1);
    return (nxt == size) ? '0 : nxt[PTR_W-1:0];
  endfunction

  // Byte store and its registered read data.
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] mem_q;

  // Buffer state.
  logic [SIZE_W-1:0] size_r;
  logic [SIZE_W-1:0] filled_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [PTR_W-1:0]  wr_ptr_r;

  // Open write run.
  logic              run_open_r;
  logic              run_acc_r;
  logic [LEN_W-1:0]  run_left_r;
  logic [LEN_W-1:0]  run_total_r;
  logic [PTR_W-1:0]  stage_ptr_r;

  // Read sequencer.
  logic              reading_r;
  logic [SIZE_W-1:0] rd_left_r;
  logic [LEN_W-1:0]  rd_total_r;

  logic                   take;
  logic                   in_acc;
  logic                   wr_item;
  logic                   rd_item;
  logic                   first;
  logic                   len_ok;
  logic                   eff_acc;
  logic [LEN_W-1:0]       eff_left;
  logic [LEN_W-1:0]       eff_total;
  logic [PTR_W-1:0]       eff_stage;
  logic [PTR_W-1:0]       stage_inc;
  logic [LEN_W-1:0]       left_dec;
  logic                   zero_run;
  logic                   run_done;
  logic                   mem_we;
  logic                   rd_ok;
  logic                   rd_issue;
  logic                   load;
  logic [LEN_W-1:0]       cfg_sat;
  abrb_pkg::result_meta_t meta;

  // Input handshake: idle sequencer and room in the result path.
  assign in_bus.ready = !reading_r && take;
  assign in_acc       = in_bus.valid && in_bus.ready;
  assign wr_item      = in_acc && (in_bus.op == abrb_pkg::OP_WRITE);
  assign rd_item      = in_acc && (in_bus.op == abrb_pkg::OP_READ);

  // Write run: the first beat sets length and verdict, later beats use the stored ones.
  assign first     = !run_open_r;
  assign len_ok    = (in_bus.length != '0) &&
                     (in_bus.length <= LEN_W'(size_r - filled_r));
  assign eff_acc   = first ? len_ok : run_acc_r;
  assign eff_left  = first ? in_bus.length : run_left_r;
  assign eff_total = first ? in_bus.length : run_total_r;
  assign eff_stage = first ? wr_ptr_r : stage_ptr_r;
  assign stage_inc = ptr_inc(eff_stage, size_r);
  assign zero_run  = first && (in_bus.length == '0);
  assign left_dec  = eff_left - LEN_W'(1);
  assign run_done  = zero_run || (left_dec == '0);
  assign mem_we    = wr_item && !zero_run && eff_acc;

  // Read request: served only from committed bytes.
  assign rd_ok    = (in_bus.length != '0) && (in_bus.length <= LEN_W'(filled_r));
  assign rd_issue = reading_r && take;

  // Saturate the configured size into 1..DEPTH.
  always_comb begin
    if (cfg_wr_data == '0) begin
      cfg_sat = LEN_W'(1);
    end else if (cfg_wr_data > LEN_W'(DEPTH)) begin
      cfg_sat = LEN_W'(DEPTH);
    end else begin
      cfg_sat = cfg_wr_data;
    end
  end

  // Result descriptor: a read byte from the sequencer, else a write status or an empty read result.
  always_comb begin
    meta = '0;
    if (rd_issue) begin
      meta.kind     = abrb_pkg::KIND_RDATA;
      meta.count    = rd_total_r;
      meta.last     = (rd_left_r == SIZE_W'(1));
      meta.from_mem = 1'b1;
    end else begin
      meta.kind     = wr_item ? abrb_pkg::KIND_WSTAT : abrb_pkg::KIND_RDATA;
      meta.count    = (wr_item && eff_acc) ? eff_total : '0;
      meta.last     = 1'b1;
      meta.from_mem = 1'b0;
    end
  end

  assign load = rd_issue || (wr_item && run_done) || (rd_item && !rd_ok);

  // Byte store. Staged writes land outside the committed region and no item is taken
  // while a read is running, so a read never meets a write to the same entry.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[eff_stage] <= in_bus.data_in;
    end
    if (rd_issue) begin
      mem_q <= mem[rd_ptr_r];
    end
  end

  // Control state; a configuration write empties the buffer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= SIZE_W'(DEPTH);
      filled_r    <= '0;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      run_open_r  <= 1'b0;
      run_acc_r   <= 1'b0;
      run_left_r  <= '0;
      run_total_r <= '0;
      stage_ptr_r <= '0;
      reading_r   <= 1'b0;
      rd_left_r   <= '0;
      rd_total_r  <= '0;
    end else if (cfg_wr_en) begin
      size_r      <= SIZE_W'(cfg_sat);
      filled_r    <= '0;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      run_open_r  <= 1'b0;
      run_acc_r   <= 1'b0;
      run_left_r  <= '0;
      run_total_r <= '0;
      reading_r   <= 1'b0;
      rd_left_r   <= '0;
    end else begin
      // Write beats stage bytes and commit an accepted run on its final beat.
      if (wr_item && !zero_run) begin
        run_open_r  <= !run_done;
        run_acc_r   <= eff_acc;
        run_left_r  <= left_dec;
        run_total_r <= eff_total;
        stage_ptr_r <= stage_inc;
        if (run_done && eff_acc) begin
          wr_ptr_r <= stage_inc;
          filled_r <= filled_r + SIZE_W'(eff_total);
        end
      end
      // Accepted read: claim the bytes now, deliver them one per cycle unless the output stalls.
      if (rd_item && rd_ok) begin
        reading_r  <= 1'b1;
        rd_left_r  <= SIZE_W'(in_bus.length);
        rd_total_r <= in_bus.length;
        filled_r   <= filled_r - SIZE_W'(in_bus.length);
      end
      if (rd_issue) begin
        rd_ptr_r  <= ptr_inc(rd_ptr_r, size_r);
        rd_left_r <= rd_left_r - SIZE_W'(1);
        if (rd_left_r == SIZE_W'(1)) begin
          reading_r <= 1'b0;
        end
      end
    end
  end

  abrb_result_pipe u_result_pipe (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (load),
    .meta    (meta),
    .mem_q   (mem_q),
    .take    (take),
    .out_bus (out_bus)
  );

  // Checks on occupancy, pointers and the read sequencer.
  `ABRB_ASSERT_IMPL(a_fill_bound, clk, rst_n, 1'b1, filled_r <= size_r)
  `ABRB_ASSERT_IMPL(a_ptr_bound, clk, rst_n, 1'b1, (SIZE_W'(wr_ptr_r) < size_r) && (SIZE_W'(rd_ptr_r) < size_r))
  `ABRB_ASSERT_NEXT(a_read_start, clk, rst_n, rd_item && rd_ok && !cfg_wr_en, reading_r)
  `ABRB_ASSERT_IMPL(a_read_left, clk, rst_n, reading_r, rd_left_r != '0)

endmodule
